[rtl/header_parameter_tokenizer_core_defines.svh]
// Assertion macros used by the checker file of the header parameter tokenizer.
`ifndef HEADER_PARAMETER_TOKENIZER_CORE_DEFINES_SVH
`define HEADER_PARAMETER_TOKENIZER_CORE_DEFINES_SVH

// clocked assertion, masked while reset is high
`define HPT_ASSERT_ON(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error(msg);

// clocked assertion that also holds across reset
`define HPT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/hpt_pkg.sv]
// Package of the header parameter tokenizer: codes, command type and helpers.
package hpt_pkg;

   localparam int WS_DEPTH_DEF = 32;

   localparam int Q_DEPTH = 4;
   localparam int Q_PTR_W = $clog2(Q_DEPTH);
   localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_LPAREN  = 8'h28;
   localparam logic [7:0] CH_RPAREN  = 8'h29;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_DQUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH  = 8'h5C;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_WS_LO   = 8'h09;
   localparam logic [7:0] CH_WS_HI   = 8'h0D;

   localparam int FLAG_NO_COMMENT = 0;
   localparam int FLAG_NO_QUOTE   = 1;
   localparam int FLAG_NO_PRIMARY = 2;

   localparam logic [1:0] KIND_PRIMARY = 2'd0;
   localparam logic [1:0] KIND_KEY     = 2'd1;
   localparam logic [1:0] KIND_VALUE   = 2'd2;

   typedef enum logic [2:0] {
      LX_RAW     = 3'd0,
      LX_DQ      = 3'd1,
      LX_DQ_ESC  = 3'd2,
      LX_CMT     = 3'd3,
      LX_CMT_ESC = 3'd4
   } lex_type;

   typedef enum logic [1:0] {
      ACT_NONE = 2'd0,
      ACT_WS   = 2'd1,
      ACT_CHAR = 2'd2
   } act_type;

   typedef enum logic [1:0] {
      BK_LOAD  = 2'd0,
      BK_FLUSH = 2'd1,
      BK_WS    = 2'd2,
      BK_MARK  = 2'd3
   } back_state_type;

   // one classified item as handed from front to back
   typedef struct packed {
      logic [7:0] data;
      logic [1:0] kind;
      act_type    act;
      logic       clr;
      logic       mark;
      logic       hdr;
   } cmd_type;

   function automatic logic is_ws(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_WS_LO) && (c <= CH_WS_HI));
   endfunction

endpackage

[rtl/hpt_front.sv]
// Front end: takes header bytes, tracks quote/comment/part state, issues commands.
module hpt_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_wr_en,
   input  logic [2:0]       csr_parse_flags,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_in_byte,
   input  logic             req_in_last,
   input  logic             q_full,
   output logic             q_push,
   output hpt_pkg::cmd_type q_cmd
);

   logic [2:0]       flags_ff;
   hpt_pkg::lex_type lex_ff, lex_in;
   logic [1:0]       kind_ff, kind_in;
   logic             open_ff, open_in;
   logic             started_ff, started_in;

   hpt_pkg::lex_type lex0;
   logic [1:0]       kind0;
   logic             started0;
   logic             content;
   logic             term;
   logic             accept;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;

   always_comb begin
      lex0     = open_ff ? lex_ff : hpt_pkg::LX_RAW;
      started0 = open_ff ? started_ff : 1'b0;
      kind0    = kind_ff;
      if (!open_ff && (kind_ff == hpt_pkg::KIND_PRIMARY)
          && flags_ff[hpt_pkg::FLAG_NO_PRIMARY]) begin
         kind0 = hpt_pkg::KIND_KEY;
      end

      content = 1'b0;
      term    = 1'b0;
      lex_in  = hpt_pkg::LX_RAW;
      unique case (lex0)
         hpt_pkg::LX_DQ: begin
            lex_in = hpt_pkg::LX_DQ;
            if (req_in_byte == hpt_pkg::CH_BSLASH) begin
               lex_in = hpt_pkg::LX_DQ_ESC;
            end else if (req_in_byte == hpt_pkg::CH_DQUOTE) begin
               lex_in = hpt_pkg::LX_RAW;
            end else begin
               content = 1'b1;
            end
         end
         hpt_pkg::LX_DQ_ESC: begin
            content = 1'b1;
            lex_in  = hpt_pkg::LX_DQ;
         end
         hpt_pkg::LX_CMT: begin
            lex_in = hpt_pkg::LX_CMT;
            if (req_in_byte == hpt_pkg::CH_RPAREN) begin
               lex_in = hpt_pkg::LX_RAW;
            end else if (req_in_byte == hpt_pkg::CH_BSLASH) begin
               lex_in = hpt_pkg::LX_CMT_ESC;
            end
         end
         hpt_pkg::LX_CMT_ESC: begin
            lex_in = hpt_pkg::LX_CMT;
         end
         default: begin
            priority if (req_in_byte == hpt_pkg::CH_DQUOTE
                         && !flags_ff[hpt_pkg::FLAG_NO_QUOTE]) begin
               lex_in = hpt_pkg::LX_DQ;
            end else if (req_in_byte == hpt_pkg::CH_LPAREN
                         && !flags_ff[hpt_pkg::FLAG_NO_COMMENT]) begin
               lex_in = hpt_pkg::LX_CMT;
            end else if (req_in_byte == hpt_pkg::CH_SEMI) begin
               term = 1'b1;
            end else begin
               content = 1'b1;
            end
         end
      endcase

      kind_in    = kind0;
      started_in = started0;
      open_in    = 1'b1;
      q_cmd.data = req_in_byte;
      q_cmd.act  = hpt_pkg::ACT_NONE;
      q_cmd.clr  = 1'b0;
      q_cmd.mark = 1'b0;
      q_cmd.hdr  = req_in_last;

      if (content) begin
         if ((kind0 == hpt_pkg::KIND_KEY) && (req_in_byte == hpt_pkg::CH_EQUAL)) begin
            kind_in    = hpt_pkg::KIND_VALUE;
            started_in = 1'b0;
            q_cmd.clr  = 1'b1;
         end else if (hpt_pkg::is_ws(req_in_byte)) begin
            if (started0) begin
               q_cmd.act = hpt_pkg::ACT_WS;
            end
         end else begin
            q_cmd.act  = hpt_pkg::ACT_CHAR;
            started_in = 1'b1;
         end
      end
      q_cmd.kind = kind_in;

      if (term || req_in_last) begin
         q_cmd.mark = 1'b1;
         open_in    = 1'b0;
         lex_in     = hpt_pkg::LX_RAW;
         started_in = 1'b0;
         kind_in    = req_in_last ? hpt_pkg::KIND_PRIMARY : hpt_pkg::KIND_KEY;
      end

      q_push = accept && (q_cmd.clr || q_cmd.mark || (q_cmd.act != hpt_pkg::ACT_NONE));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         flags_ff   <= '0;
         lex_ff     <= hpt_pkg::LX_RAW;
         kind_ff    <= hpt_pkg::KIND_PRIMARY;
         open_ff    <= 1'b0;
         started_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            flags_ff <= csr_parse_flags;
         end
         if (accept) begin
            lex_ff     <= lex_in;
            kind_ff    <= kind_in;
            open_ff    <= open_in;
            started_ff <= started_in;
         end
      end
   end

endmodule

[rtl/hpt_queue.sv]
// Short command queue between front and back end.
module hpt_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  hpt_pkg::cmd_type wr_cmd,
   output logic             full,
   input  logic             rd_en,
   output hpt_pkg::cmd_type rd_cmd,
   output logic             empty
);

   hpt_pkg::cmd_type                 slot_ff [hpt_pkg::Q_DEPTH];
   logic [hpt_pkg::Q_PTR_W-1:0]      wr_ptr_ff;
   logic [hpt_pkg::Q_PTR_W-1:0]      rd_ptr_ff;
   logic [hpt_pkg::Q_CNT_W-1:0]      cnt_ff;

   assign full   = (cnt_ff == hpt_pkg::Q_CNT_W'(hpt_pkg::Q_DEPTH));
   assign empty  = (cnt_ff == '0);
   assign rd_cmd = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         slot_ff[wr_ptr_ff] <= wr_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         if (wr_en) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rd_en) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (wr_en && !rd_en) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (rd_en && !wr_en) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

endmodule

[rtl/hpt_back.sv]
// Back end: pending whitespace store and result sequencer with output register.
module hpt_back #(
   parameter int WS_DEPTH = hpt_pkg::WS_DEPTH_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             q_empty,
   input  hpt_pkg::cmd_type q_cmd,
   output logic             q_pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [7:0]       rsp_out_byte,
   output logic             rsp_has_data,
   output logic [1:0]       rsp_field_kind,
   output logic             rsp_end_part,
   output logic             rsp_end_header,
   output logic             rsp_ws_overflow,
   output logic             rsp_run_last
);

   localparam int PTR_W = (WS_DEPTH > 1) ? $clog2(WS_DEPTH) : 1;
   localparam int CNT_W = $clog2(WS_DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(WS_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(WS_DEPTH);

   hpt_pkg::back_state_type state_ff, state_in;
   hpt_pkg::cmd_type        cur_ff, cur_in;
   logic [PTR_W-1:0]        head_ff, head_in;
   logic [PTR_W-1:0]        tail_ff, tail_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   logic [7:0]              rdata_ff;
   logic [7:0]              ws_mem [WS_DEPTH];

   logic                    we;
   logic                    adv;
   logic                    out_go;
   logic [7:0]              o_byte;
   logic                    o_has;
   logic                    o_ep;
   logic                    o_eh;
   logic                    o_ovf;
   logic                    o_last;

   logic                    valid_ff, valid_in;
   logic [7:0]              byte_ff;
   logic                    has_ff;
   logic [1:0]              kind_ff;
   logic                    ep_ff;
   logic                    eh_ff;
   logic                    ovf_ff;
   logic                    last_ff;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == PTR_LAST) ? '0 : p + 1'b1;
   endfunction

   assign adv = !valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cur_in   = cur_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      cnt_in   = cnt_ff;
      q_pop    = 1'b0;
      we       = 1'b0;
      out_go   = 1'b0;
      o_byte   = '0;
      o_has    = 1'b0;
      o_ep     = 1'b0;
      o_eh     = 1'b0;
      o_ovf    = 1'b0;
      o_last   = 1'b0;

      unique case (state_ff)
         hpt_pkg::BK_LOAD: begin
            if (!q_empty) begin
               q_pop  = 1'b1;
               cur_in = q_cmd;
               if (q_cmd.clr) begin
                  head_in = '0;
                  tail_in = '0;
                  cnt_in  = '0;
               end
               unique case (q_cmd.act)
                  hpt_pkg::ACT_WS:   state_in = hpt_pkg::BK_WS;
                  hpt_pkg::ACT_CHAR: state_in = hpt_pkg::BK_FLUSH;
                  default:           state_in = q_cmd.mark ? hpt_pkg::BK_MARK
                                                           : hpt_pkg::BK_LOAD;
               endcase
            end
         end
         hpt_pkg::BK_FLUSH: begin
            if (adv) begin
               out_go = 1'b1;
               o_has  = 1'b1;
               if (cnt_ff != '0) begin
                  o_byte  = rdata_ff;
                  head_in = ptr_inc(head_ff);
                  cnt_in  = cnt_ff - 1'b1;
               end else begin
                  o_byte   = cur_ff.data;
                  o_last   = !cur_ff.mark;
                  state_in = cur_ff.mark ? hpt_pkg::BK_MARK : hpt_pkg::BK_LOAD;
               end
            end
         end
         hpt_pkg::BK_WS: begin
            if (cnt_ff == CNT_FULL) begin
               if (adv) begin
                  out_go   = 1'b1;
                  o_has    = 1'b1;
                  o_byte   = rdata_ff;
                  o_ovf    = 1'b1;
                  o_last   = !cur_ff.mark;
                  we       = 1'b1;
                  head_in  = ptr_inc(head_ff);
                  tail_in  = ptr_inc(tail_ff);
                  state_in = cur_ff.mark ? hpt_pkg::BK_MARK : hpt_pkg::BK_LOAD;
               end
            end else begin
               we       = 1'b1;
               tail_in  = ptr_inc(tail_ff);
               cnt_in   = cnt_ff + 1'b1;
               state_in = cur_ff.mark ? hpt_pkg::BK_MARK : hpt_pkg::BK_LOAD;
            end
         end
         hpt_pkg::BK_MARK: begin
            if (adv) begin
               out_go   = 1'b1;
               o_ep     = 1'b1;
               o_eh     = cur_ff.hdr;
               o_last   = 1'b1;
               head_in  = '0;
               tail_in  = '0;
               cnt_in   = '0;
               state_in = hpt_pkg::BK_LOAD;
            end
         end
         default: begin
            state_in = hpt_pkg::BK_LOAD;
         end
      endcase

      valid_in = valid_ff && !rsp_ready;
      if (out_go) begin
         valid_in = 1'b1;
      end
   end

   // store write at the tail; head byte always prefetched into rdata_ff
   always_ff @(posedge clock) begin
      if (we) begin
         ws_mem[tail_ff] <= cur_ff.data;
      end
   end

   always_ff @(posedge clock) begin
      if (we && (tail_ff == head_in)) begin
         rdata_ff <= cur_ff.data;
      end else begin
         rdata_ff <= ws_mem[head_in];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hpt_pkg::BK_LOAD;
         head_ff  <= '0;
         tail_ff  <= '0;
         cnt_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         cnt_ff   <= cnt_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (out_go) begin
         byte_ff <= o_byte;
         has_ff  <= o_has;
         kind_ff <= cur_ff.kind;
         ep_ff   <= o_ep;
         eh_ff   <= o_eh;
         ovf_ff  <= o_ovf;
         last_ff <= o_last;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_out_byte    = byte_ff;
   assign rsp_has_data    = has_ff;
   assign rsp_field_kind  = kind_ff;
   assign rsp_end_part    = ep_ff;
   assign rsp_end_header  = eh_ff;
   assign rsp_ws_overflow = ovf_ff;
   assign rsp_run_last    = last_ff;

endmodule

[rtl/header_parameter_tokenizer_core.sv]
// Top level of the header parameter tokenizer: front end, command queue, back end.
//
//   port group  direction  handshake          payload
//   req_        in         req_valid/ready    in_byte, in_last
//   rsp_        out        rsp_valid/ready    out_byte .. run_last
//   csr_        in         csr_wr_en          parse_flags
//
// Front end accepts one item per cycle while the 4-entry command queue has room.
// Back end loads a command and emits its results in order (flushed pending whitespace,
// content byte, end marker), each when the output register can advance; a stored space
// emits nothing, or the oldest pending byte flagged as overflow if the store is full.
// Synchronous active-high reset; the whitespace store needs no clearing pass.
// rsp_ready low stalls the back end only; the front end runs until the queue fills.
module header_parameter_tokenizer_core #(
   parameter int WS_DEPTH = hpt_pkg::WS_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_wr_en,
   input  logic [2:0] csr_parse_flags,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_data,
   output logic [1:0] rsp_field_kind,
   output logic       rsp_end_part,
   output logic       rsp_end_header,
   output logic       rsp_ws_overflow,
   output logic       rsp_run_last
);

   hpt_pkg::cmd_type push_cmd;
   hpt_pkg::cmd_type pop_cmd;
   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;

   hpt_front u_front (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_parse_flags (csr_parse_flags),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_in_byte     (req_in_byte),
      .req_in_last     (req_in_last),
      .q_full          (q_full),
      .q_push          (q_push),
      .q_cmd           (push_cmd)
   );

   hpt_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_push),
      .wr_cmd (push_cmd),
      .full   (q_full),
      .rd_en  (q_pop),
      .rd_cmd (pop_cmd),
      .empty  (q_empty)
   );

   hpt_back #(
      .WS_DEPTH (WS_DEPTH)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .q_empty         (q_empty),
      .q_cmd           (pop_cmd),
      .q_pop           (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_has_data    (rsp_has_data),
      .rsp_field_kind  (rsp_field_kind),
      .rsp_end_part    (rsp_end_part),
      .rsp_end_header  (rsp_end_header),
      .rsp_ws_overflow (rsp_ws_overflow),
      .rsp_run_last    (rsp_run_last)
   );

endmodule

[rtl/hpt_checker.sv]
// Port-level checker for the header parameter tokenizer, bound to the top level.
`include "header_parameter_tokenizer_core_defines.svh"

module hpt_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_out_byte,
   input logic       rsp_has_data,
   input logic [1:0] rsp_field_kind,
   input logic       rsp_end_part,
   input logic       rsp_end_header,
   input logic       rsp_ws_overflow,
   input logic       rsp_run_last
);

   logic        stall;
   logic [14:0] payload;
   logic        marker;
   logic        marker_ok;
   logic        hdr_end;
   logic        ovf_out;
   logic        ovf_ok;

   assign stall     = rsp_valid && !rsp_ready;
   assign payload   = {rsp_out_byte, rsp_has_data, rsp_field_kind, rsp_end_part,
                       rsp_end_header, rsp_ws_overflow, rsp_run_last};
   assign marker    = rsp_valid && rsp_end_part;
   assign marker_ok = !rsp_has_data && !rsp_ws_overflow && rsp_run_last
                      && (rsp_out_byte == 8'h00);
   assign hdr_end   = rsp_valid && rsp_end_header;
   assign ovf_out   = rsp_valid && rsp_ws_overflow;
   assign ovf_ok    = rsp_has_data && hpt_pkg::is_ws(rsp_out_byte);

   `HPT_ASSERT_ALWAYS(a_reset_quiet, clock, reset |=> !rsp_valid, "valid after reset")

   `HPT_ASSERT_ON(a_rsp_hold, clock, reset, stall |=> rsp_valid && $stable(payload), "item moved")

   `HPT_ASSERT_ON(a_marker_shape, clock, reset, marker |-> marker_ok, "malformed end marker")

   `HPT_ASSERT_ON(a_header_in_part, clock, reset, hdr_end |-> rsp_end_part, "lone end_header")

   `HPT_ASSERT_ON(a_ovf_is_ws, clock, reset, ovf_out |-> ovf_ok, "overflow byte not whitespace")

endmodule

bind header_parameter_tokenizer_core hpt_checker u_hpt_checker (.*);

[tb/sv/header_parameter_tokenizer_core_tb.sv]
// Self-checking testbench of the header parameter tokenizer: directed table, random headers.
module header_parameter_tokenizer_core_tb;
   import hpt_pkg::*;

   localparam int WS_DEPTH    = WS_DEPTH_DEF;
   localparam int DRAIN_WAIT  = 24;
   localparam int QUIET_LIMIT = 3000;
   localparam int PRINT_CAP   = 60;
   localparam int PHASE_ITEMS = 4;

   typedef struct packed {
      logic [7:0] data;
      logic       has;
      logic [1:0] kind;
      logic       ep;
      logic       eh;
      logic       ovf;
      logic       rl;
   } token_type;

   typedef struct packed {
      logic [7:0] b;
      logic       l;
      logic       typed;
      token_type  want;
   } dir_row_type;

   localparam token_type NO_TOK = '0;

   logic       clock;
   logic       reset = 1'b1;
   logic       csr_wr_en = 1'b0;
   logic [2:0] csr_parse_flags = '0;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte = '0;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_data;
   logic [1:0] rsp_field_kind;
   logic       rsp_end_part;
   logic       rsp_end_header;
   logic       rsp_ws_overflow;
   logic       rsp_run_last;

   // tokenizer state as predicted
   logic [2:0] flags = '0;
   lex_type    lex_st = LX_RAW;
   logic [1:0] part_kind = KIND_PRIMARY;
   logic       part_open = 1'b0;
   logic       field_started = 1'b0;
   logic [7:0] ws_store [WS_DEPTH];
   int         ws_cnt = 0;

   token_type  step_q [$];
   token_type  token_q [$];
   logic [7:0] hdr_bytes [$];

   int fails = 0;
   int items_sent = 0;
   int rsp_count = 0;
   int quiet = 0;
   int burst_left = 0;
   int rx_left = 0;
   int rx_mode = 0;

   logic [2:0] phase_flags [8] = '{3'd7, 3'd0, 3'd1, 3'd2, 3'd4, 3'd3, 3'd5, 3'd6};

   dir_row_type dir_rows [25] = '{
      '{8'h61,     1'b0, 1'b1, '{8'h61, 1'b1, KIND_PRIMARY, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{CH_SPACE,  1'b0, 1'b0, NO_TOK},
      '{CH_DQUOTE, 1'b0, 1'b0, NO_TOK},
      '{8'h62,     1'b0, 1'b0, NO_TOK},
      '{CH_BSLASH, 1'b0, 1'b0, NO_TOK},
      '{CH_DQUOTE, 1'b0, 1'b0, NO_TOK},
      '{CH_DQUOTE, 1'b0, 1'b0, NO_TOK},
      '{CH_LPAREN, 1'b0, 1'b0, NO_TOK},
      '{CH_BSLASH, 1'b0, 1'b0, NO_TOK},
      '{CH_RPAREN, 1'b0, 1'b0, NO_TOK},
      '{CH_RPAREN, 1'b0, 1'b0, NO_TOK},
      '{8'h09,     1'b0, 1'b0, NO_TOK},
      '{CH_SEMI,   1'b0, 1'b1, '{8'h00, 1'b0, KIND_PRIMARY, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{8'h0D,     1'b0, 1'b0, NO_TOK},
      '{8'h6B,     1'b0, 1'b0, NO_TOK},
      '{CH_DQUOTE, 1'b0, 1'b0, NO_TOK},
      '{CH_EQUAL,  1'b0, 1'b0, NO_TOK},
      '{CH_DQUOTE, 1'b0, 1'b0, NO_TOK},
      '{8'hFF,     1'b0, 1'b1, '{8'hFF, 1'b1, KIND_VALUE, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{CH_SEMI,   1'b0, 1'b0, NO_TOK},
      '{CH_SEMI,   1'b0, 1'b1, '{8'h00, 1'b0, KIND_KEY, 1'b1, 1'b0, 1'b0, 1'b1}},
      '{8'h00,     1'b0, 1'b1, '{8'h00, 1'b1, KIND_KEY, 1'b0, 1'b0, 1'b0, 1'b1}},
      '{CH_DQUOTE, 1'b0, 1'b0, NO_TOK},
      '{CH_SEMI,   1'b1, 1'b0, NO_TOK},
      '{CH_SEMI,   1'b1, 1'b1, '{8'h00, 1'b0, KIND_PRIMARY, 1'b1, 1'b1, 1'b0, 1'b1}}
   };

   header_parameter_tokenizer_core #(
      .WS_DEPTH(WS_DEPTH)
   ) u_top (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_parse_flags(csr_parse_flags),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_in_byte(req_in_byte),
      .req_in_last(req_in_last),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_out_byte(rsp_out_byte),
      .rsp_has_data(rsp_has_data),
      .rsp_field_kind(rsp_field_kind),
      .rsp_end_part(rsp_end_part),
      .rsp_end_header(rsp_end_header),
      .rsp_ws_overflow(rsp_ws_overflow),
      .rsp_run_last(rsp_run_last)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic logic blank_char(input logic [7:0] c);
      return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
   endfunction

   function automatic void emit(input logic [7:0] d, input logic h, input logic ep,
                                input logic eh, input logic ov);
      token_type t;
      t.data = d;
      t.has  = h;
      t.kind = part_kind;
      t.ep   = ep;
      t.eh   = eh;
      t.ovf  = ov;
      t.rl   = 1'b0;
      step_q.push_back(t);
   endfunction

   // results of one item into step_q
   function automatic void tokenize(input logic [7:0] c, input logic l);
      logic      content;
      logic      term;
      token_type t;
      content = 1'b0;
      term    = 1'b0;
      step_q.delete();
      if (!part_open) begin
         if (part_kind == KIND_PRIMARY && flags[FLAG_NO_PRIMARY])
            part_kind = KIND_KEY;
         part_open     = 1'b1;
         lex_st        = LX_RAW;
         field_started = 1'b0;
         ws_cnt        = 0;
      end
      case (lex_st)
         LX_DQ: begin
            if (c == CH_BSLASH) lex_st = LX_DQ_ESC;
            else if (c == CH_DQUOTE) lex_st = LX_RAW;
            else content = 1'b1;
         end
         LX_DQ_ESC: begin
            content = 1'b1;
            lex_st  = LX_DQ;
         end
         LX_CMT: begin
            if (c == CH_RPAREN) lex_st = LX_RAW;
            else if (c == CH_BSLASH) lex_st = LX_CMT_ESC;
         end
         LX_CMT_ESC: lex_st = LX_CMT;
         default: begin
            lex_st = LX_RAW;
            if (c == CH_DQUOTE && !flags[FLAG_NO_QUOTE]) lex_st = LX_DQ;
            else if (c == CH_LPAREN && !flags[FLAG_NO_COMMENT]) lex_st = LX_CMT;
            else if (c == CH_SEMI) term = 1'b1;
            else content = 1'b1;
         end
      endcase
      if (content) begin
         if (part_kind == KIND_KEY && c == CH_EQUAL) begin
            part_kind     = KIND_VALUE;
            field_started = 1'b0;
            ws_cnt        = 0;
         end else if (blank_char(c)) begin
            if (field_started) begin
               if (ws_cnt >= WS_DEPTH) begin
                  emit(ws_store[0], 1'b1, 1'b0, 1'b0, 1'b1);
                  for (int i = 0; i < WS_DEPTH - 1; i++)
                     ws_store[i] = ws_store[i+1];
                  ws_cnt = WS_DEPTH - 1;
               end
               ws_store[ws_cnt] = c;
               ws_cnt++;
            end
         end else begin
            for (int i = 0; i < ws_cnt; i++)
               emit(ws_store[i], 1'b1, 1'b0, 1'b0, 1'b0);
            ws_cnt = 0;
            emit(c, 1'b1, 1'b0, 1'b0, 1'b0);
            field_started = 1'b1;
         end
      end
      if (term || l) begin
         emit(8'h00, 1'b0, 1'b1, l, 1'b0);
         part_open     = 1'b0;
         lex_st        = LX_RAW;
         field_started = 1'b0;
         ws_cnt        = 0;
         part_kind     = l ? KIND_PRIMARY : KIND_KEY;
      end
      if (step_q.size() != 0) begin
         t = step_q.pop_back();
         t.rl = 1'b1;
         step_q.push_back(t);
      end
   endfunction

   task automatic report(input string what, input logic [7:0] got, input logic [7:0] want);
      if (fails < PRINT_CAP)
         $display("ERROR: result %0d %s: got %0h, want %0h", rsp_count, what, got, want);
      fails++;
   endtask

   task automatic send_item(input logic [7:0] b, input logic l, input logic typed,
                            input token_type want);
      if (burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                  : $urandom_range(1, 8);
      end
      req_valid   <= 1'b1;
      req_in_byte <= b;
      req_in_last <= l;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      burst_left--;
      items_sent++;
      tokenize(b, l);
      if (typed) token_q.push_back(want);
      else foreach (step_q[i]) token_q.push_back(step_q[i]);
   endtask

   // sender stops until every result is in and the block has gone quiet
   task automatic settle();
      req_valid <= 1'b0;
      while (token_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
   endtask

   task automatic write_flags(input logic [2:0] v);
      csr_parse_flags <= v;
      csr_wr_en       <= 1'b1;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      flags = v;
   endtask

   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 15))
         0, 1, 2, 3, 4, 5: return 8'($urandom_range(8'h61, 8'h7A));
         6: return CH_SPACE;
         7: return 8'($urandom_range(8'h09, 8'h0D));
         8: return CH_DQUOTE;
         9: return CH_BSLASH;
         10: return CH_LPAREN;
         11: return CH_RPAREN;
         12: return CH_SEMI;
         13: return CH_EQUAL;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic void add_ws(input int n);
      repeat (n)
         hdr_bytes.push_back(($urandom_range(0, 2) == 0) ? 8'($urandom_range(8'h09, 8'h0D))
                                                         : CH_SPACE);
   endfunction

   function automatic void add_word();
      repeat ($urandom_range(1, 5)) begin
         if ($urandom_range(0, 5) == 0) hdr_bytes.push_back(pick_byte());
         else if ($urandom_range(0, 1)) hdr_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
         else hdr_bytes.push_back(8'($urandom_range(8'h30, 8'h39)));
      end
   endfunction

   // one header: mostly primary;key=value;... with random content, some pure noise
   task automatic run_header(input bit long_ws, input bit split_cfg);
      int nparts;
      int n;
      hdr_bytes.delete();
      if ($urandom_range(0, 4) == 0) begin
         repeat ($urandom_range(1, 10)) hdr_bytes.push_back(pick_byte());
      end else begin
         nparts = $urandom_range(1, 4);
         for (int p = 0; p < nparts; p++) begin
            if (p != 0) hdr_bytes.push_back(CH_SEMI);
            add_ws($urandom_range(0, 2));
            add_word();
            if (p != 0 || $urandom_range(0, 3) == 0) begin
               add_ws($urandom_range(0, 1));
               hdr_bytes.push_back(CH_EQUAL);
               add_ws($urandom_range(0, 1));
               if ($urandom_range(0, 1)) begin
                  hdr_bytes.push_back(CH_DQUOTE);
                  repeat ($urandom_range(0, 4)) begin
                     if ($urandom_range(0, 3) == 0) begin
                        hdr_bytes.push_back(CH_BSLASH);
                        hdr_bytes.push_back(8'($urandom_range(0, 255)));
                     end else begin
                        hdr_bytes.push_back(pick_byte());
                     end
                  end
                  if ($urandom_range(0, 7) != 0) hdr_bytes.push_back(CH_DQUOTE);
               end else begin
                  add_word();
               end
            end
            if ($urandom_range(0, 4) == 0) begin
               hdr_bytes.push_back(CH_LPAREN);
               repeat ($urandom_range(0, 3)) begin
                  n = $urandom_range(0, 3);
                  if (n == 0) begin
                     hdr_bytes.push_back(CH_BSLASH);
                     hdr_bytes.push_back(8'($urandom_range(0, 255)));
                  end else if (n == 1) begin
                     hdr_bytes.push_back(CH_SEMI);
                  end else begin
                     hdr_bytes.push_back(8'($urandom_range(8'h61, 8'h7A)));
                  end
               end
               hdr_bytes.push_back(CH_RPAREN);
            end
            add_ws($urandom_range(0, 2));
         end
      end
      if (long_ws) begin
         hdr_bytes.push_back(8'h78);
         add_ws($urandom_range(WS_DEPTH + 1, WS_DEPTH + 4));
         hdr_bytes.push_back(8'h79);
      end
      if ($urandom_range(0, 5) == 0) hdr_bytes.push_back(CH_SEMI);
      for (int i = 0; i < hdr_bytes.size(); i++) begin
         if (split_cfg && i != 0 && i == hdr_bytes.size() / 2) begin
            settle();
            write_flags(3'($urandom_range(0, 7)));
         end
         send_item(hdr_bytes[i], i == hdr_bytes.size() - 1, 1'b0, NO_TOK);
      end
   endtask

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = $urandom_range(0, 3);
         rx_left = $urandom_range(32, 200);
      end else begin
         rx_left--;
      end
      case (rx_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         2: rsp_ready <= (rx_left % 4 == 0);
         default: rsp_ready <= ($urandom_range(0, 9) == 0);
      endcase
   end

   token_type want_tok;

   always @(posedge clock) begin
      if (reset) begin
         quiet = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (token_q.size() == 0) begin
               report("unexpected result, byte", rsp_out_byte, 8'h00);
            end else begin
               want_tok = token_q.pop_front();
               if (rsp_out_byte !== want_tok.data)
                  report("out_byte", rsp_out_byte, want_tok.data);
               if (rsp_has_data !== want_tok.has)
                  report("has_data", 8'(rsp_has_data), 8'(want_tok.has));
               if (rsp_field_kind !== want_tok.kind)
                  report("field_kind", 8'(rsp_field_kind), 8'(want_tok.kind));
               if (rsp_end_part !== want_tok.ep)
                  report("end_part", 8'(rsp_end_part), 8'(want_tok.ep));
               if (rsp_end_header !== want_tok.eh)
                  report("end_header", 8'(rsp_end_header), 8'(want_tok.eh));
               if (rsp_ws_overflow !== want_tok.ovf)
                  report("ws_overflow", 8'(rsp_ws_overflow), 8'(want_tok.ovf));
               if (rsp_run_last !== want_tok.rl)
                  report("run_last", 8'(rsp_run_last), 8'(want_tok.rl));
            end
            rsp_count++;
         end
         if ((rsp_valid && rsp_ready) || (req_valid && req_ready)) quiet = 0;
         else quiet++;
         if (quiet >= QUIET_LIMIT) begin
            $display("header_parameter_tokenizer_core_tb failed");
            $finish;
         end
      end
   end

   initial begin
      int phase_start;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      foreach (dir_rows[i])
         send_item(dir_rows[i].b, dir_rows[i].l, dir_rows[i].typed, dir_rows[i].want);
      for (int ph = 0; ph < 8; ph++) begin
         settle();
         write_flags(phase_flags[ph]);
         phase_start = items_sent;
         while (items_sent - phase_start < PHASE_ITEMS)
            run_header(ph == 0, ph == 5 && items_sent == phase_start);
      end
      settle();
      repeat (16) @(posedge clock);
      if (fails == 0 && token_q.size() == 0)
         $display("header_parameter_tokenizer_core_tb passed");
      else
         $display("header_parameter_tokenizer_core_tb failed");
      $finish;
   end

endmodule
